[src/dtm_pkg.sv]
// Shared constants, types and tile-bound helpers for the dirty tile map.
package dtm_pkg;

  localparam int TilePixels = 16;
  localparam int TileShift  = $clog2(TilePixels);
  localparam int MaxTiles   = 4096;
  localparam int AddrW      = $clog2(MaxTiles);
  localparam int CntW       = AddrW + 1;
  localparam int CoordW     = 24;
  localparam int GridW      = CoordW - TileShift;
  localparam int TcW        = GridW + 3;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [TcW-1:0]    tc_t;

  typedef enum logic [1:0] {
    CmdMark   = 2'd0,
    CmdResize = 2'd1,
    CmdProbe  = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StMult,
    StRow,
    StRd,
    StWr,
    StFin
  } state_e;

  // Tile bounds of one rectangle, plus whether its pixel extent is empty.
  typedef struct packed {
    tc_t  lo_x;
    tc_t  lo_y;
    tc_t  hi_x;
    tc_t  hi_y;
    logic empty;
  } rect_t;

  function automatic tc_t tile_lo(input coord_t x);
    return tc_t'(x >>> TileShift);
  endfunction

  function automatic tc_t tile_hi(input coord_t x);
    logic signed [CoordW:0] s;
    s = {x[CoordW-1], x} + (CoordW+1)'(TilePixels - 1);
    return tc_t'(s >>> TileShift);
  endfunction

endpackage

[src/dtm_if.sv]
// Command and result channel interfaces of the dirty tile map.
interface dtm_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  cmd;
  logic signed [dtm_pkg::CoordW-1:0] left;
  logic signed [dtm_pkg::CoordW-1:0] top;
  logic signed [dtm_pkg::CoordW-1:0] right;
  logic signed [dtm_pkg::CoordW-1:0] bottom;
  logic                        mark_dirty;

  modport source (output valid, cmd, left, top, right, bottom, mark_dirty, input ready);
  modport sink (input valid, cmd, left, top, right, bottom, mark_dirty, output ready);
endinterface

interface dtm_res_if;
  logic                      valid;
  logic                      ready;
  logic [dtm_pkg::CntW-1:0]  dirty_total;
  logic                      probe_dirty;
  logic                      status;

  modport source (output valid, dirty_total, probe_dirty, status, input ready);
  modport sink (input valid, dirty_total, probe_dirty, status, output ready);
endinterface

[src/dtm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dtm_ram #(
  parameter int Width = 1,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[src/dtm_bounds.sv]
// Converts a pixel rectangle to floor/ceil tile bounds and flags an empty pixel extent.
module dtm_bounds (
  input  dtm_pkg::coord_t left_i,
  input  dtm_pkg::coord_t top_i,
  input  dtm_pkg::coord_t right_i,
  input  dtm_pkg::coord_t bottom_i,
  output dtm_pkg::rect_t  rect_o
);

  always_comb begin
    rect_o.lo_x  = dtm_pkg::tile_lo(left_i);
    rect_o.lo_y  = dtm_pkg::tile_lo(top_i);
    rect_o.hi_x  = dtm_pkg::tile_hi(right_i);
    rect_o.hi_y  = dtm_pkg::tile_hi(bottom_i);
    rect_o.empty = (left_i >= right_i) || (top_i >= bottom_i);
  end

endmodule

[src/dirty_tile_map.sv]
// Top level of the dirty tile map: sequencer, grid registers and flag banks.
//
//   channel | dir | beat contents
//   in_i    | in  | cmd, left, top, right, bottom, mark_dirty
//   out_o   | out | dirty_total, probe_dirty, status
//
// A mark reads and then writes each covered tile, with a row step per row;
// a resize does the same over the whole new grid after a multiply step; a probe reads one tile.
// Tiles go one at a time because the flag banks have a single read port (read, then write).
// After reset the grid is empty, so the banks need no clearing pass.
// The block takes a new command only when idle; a result waits in the output
// register and the block stalls at its end until that register is free.
module dirty_tile_map (
  input  logic      clk_i,
  input  logic      rst_ni,
  dtm_cmd_if.sink   in_i,
  dtm_res_if.source out_o
);

  localparam int AW = dtm_pkg::AddrW;
  localparam int CW = dtm_pkg::CntW;
  localparam int GW = dtm_pkg::GridW;

  dtm_pkg::state_e state_q, state_d;
  dtm_pkg::cmd_e   cmd_q, cmd_d;
  dtm_pkg::rect_t  rect_in, rect_q, rect_d;
  logic            dv_q, dv_d;
  logic [GW-1:0]   gl_q, gl_d, gt_q, gt_d;
  logic [CW-1:0]   cols_q, cols_d, rows_q, rows_d, count_q, count_d;
  logic            bank_q, bank_d;
  logic [CW-1:0]   nh_q, nh_d, nv_q, nv_d, row_q, row_d, cnt_q, cnt_d;
  dtm_pkg::tc_t    x_q, x_d, y_q, y_d, xs_q, xs_d, xe_q, xe_d, ye_q, ye_d;
  logic [AW-1:0]   addr_q, addr_d, dst_q, dst_d;
  logic            inside_q, inside_d, probe_q, probe_d, status_q, status_d;
  logic            ovalid_q, ovalid_d, oprobe_q, oprobe_d, ostat_q, ostat_d;
  logic [CW-1:0]   otot_q, otot_d;

  dtm_pkg::tc_t    gl_x, gt_x, gr_x, gb_x, nh_w, nv_w, xs_w, xe_w, ys_w, ye_w;
  logic [2*CW-1:0] prod;
  logic            accept, fin_go, last_x, last_y, rd_live;
  logic            rd_a, rd_b, we_live, we_other, we_a, we_b, wdata;
  logic [AW-1:0]   raddr, waddr;

  dtm_bounds u_bounds (
    .left_i   (in_i.left),
    .top_i    (in_i.top),
    .right_i  (in_i.right),
    .bottom_i (in_i.bottom),
    .rect_o   (rect_in)
  );

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == dtm_pkg::StIdle);
  assign fin_go    = !ovalid_q || out_o.ready;

  assign gl_x = dtm_pkg::tc_t'($signed(gl_q));
  assign gt_x = dtm_pkg::tc_t'($signed(gt_q));
  assign gr_x = gl_x + dtm_pkg::tc_t'({1'b0, cols_q});
  assign gb_x = gt_x + dtm_pkg::tc_t'({1'b0, rows_q});
  assign nh_w = rect_q.hi_x - rect_q.lo_x;
  assign nv_w = rect_q.hi_y - rect_q.lo_y;
  assign xs_w = (rect_q.lo_x < gl_x) ? gl_x : rect_q.lo_x;
  assign xe_w = (rect_q.hi_x > gr_x) ? gr_x : rect_q.hi_x;
  assign ys_w = (rect_q.lo_y < gt_x) ? gt_x : rect_q.lo_y;
  assign ye_w = (rect_q.hi_y > gb_x) ? gb_x : rect_q.hi_y;
  assign prod = nh_q * nv_q;
  assign last_x = (x_q + dtm_pkg::tc_t'(1)) == xe_q;
  assign last_y = (y_q + dtm_pkg::tc_t'(1)) == ye_q;
  assign raddr  = row_q[AW-1:0] + AW'(x_q - gl_x);

  // Flag banks: marks write the live bank, a resize writes the other one.
  assign rd_live  = bank_q ? rd_b : rd_a;
  assign we_live  = (state_q == dtm_pkg::StWr) && (cmd_q == dtm_pkg::CmdMark);
  assign we_other = (state_q == dtm_pkg::StWr) && (cmd_q == dtm_pkg::CmdResize);
  assign we_a     = bank_q ? we_other : we_live;
  assign we_b     = bank_q ? we_live : we_other;
  assign waddr    = (cmd_q == dtm_pkg::CmdResize) ? dst_q : addr_q;
  assign wdata    = (cmd_q == dtm_pkg::CmdResize) ? (inside_q & rd_live) : dv_q;

  dtm_ram #(.Width(1), .Depth(dtm_pkg::MaxTiles)) u_bank_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_a)
  );

  dtm_ram #(.Width(1), .Depth(dtm_pkg::MaxTiles)) u_bank_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_b)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dtm_pkg::StIdle: begin
        if (accept) state_d = dtm_pkg::StCheck;
      end
      dtm_pkg::StCheck: begin
        unique case (cmd_q)
          dtm_pkg::CmdMark: begin
            if (rect_q.lo_x >= gr_x || rect_q.hi_x <= gl_x ||
                rect_q.lo_y >= gb_x || rect_q.hi_y <= gt_x ||
                xs_w >= xe_w || ys_w >= ye_w) begin
              state_d = dtm_pkg::StFin;
            end else begin
              state_d = dtm_pkg::StRow;
            end
          end
          dtm_pkg::CmdResize: begin
            if (rect_q.empty || nh_w > dtm_pkg::tc_t'(dtm_pkg::MaxTiles) ||
                nv_w > dtm_pkg::tc_t'(dtm_pkg::MaxTiles)) begin
              state_d = dtm_pkg::StFin;
            end else begin
              state_d = dtm_pkg::StMult;
            end
          end
          dtm_pkg::CmdProbe: begin
            if (rect_q.lo_x < gl_x || rect_q.lo_x >= gr_x ||
                rect_q.lo_y < gt_x || rect_q.lo_y >= gb_x) begin
              state_d = dtm_pkg::StFin;
            end else begin
              state_d = dtm_pkg::StRow;
            end
          end
          default: state_d = dtm_pkg::StFin;
        endcase
      end
      dtm_pkg::StMult: begin
        state_d = (prod > (2*CW)'(dtm_pkg::MaxTiles)) ? dtm_pkg::StFin : dtm_pkg::StRow;
      end
      dtm_pkg::StRow: state_d = dtm_pkg::StRd;
      dtm_pkg::StRd:  state_d = dtm_pkg::StWr;
      dtm_pkg::StWr: begin
        if (cmd_q == dtm_pkg::CmdProbe) begin
          state_d = dtm_pkg::StFin;
        end else if (!last_x) begin
          state_d = dtm_pkg::StRd;
        end else if (last_y) begin
          state_d = dtm_pkg::StFin;
        end else begin
          state_d = dtm_pkg::StRow;
        end
      end
      dtm_pkg::StFin: begin
        if (fin_go) state_d = dtm_pkg::StIdle;
      end
      default: state_d = dtm_pkg::StIdle;
    endcase
  end

  // Datapath and grid updates.
  always_comb begin
    cmd_d = cmd_q;       rect_d = rect_q;     dv_d = dv_q;
    gl_d = gl_q;         gt_d = gt_q;         cols_d = cols_q;
    rows_d = rows_q;     count_d = count_q;   bank_d = bank_q;
    nh_d = nh_q;         nv_d = nv_q;         row_d = row_q;
    cnt_d = cnt_q;       x_d = x_q;           y_d = y_q;
    xs_d = xs_q;         xe_d = xe_q;         ye_d = ye_q;
    addr_d = addr_q;     dst_d = dst_q;       inside_d = inside_q;
    probe_d = probe_q;   status_d = status_q;
    ovalid_d = ovalid_q && !out_o.ready;
    otot_d = otot_q;     oprobe_d = oprobe_q; ostat_d = ostat_q;

    unique case (state_q)
      dtm_pkg::StIdle: begin
        if (accept) begin
          cmd_d    = dtm_pkg::cmd_e'(in_i.cmd);
          rect_d   = rect_in;
          dv_d     = in_i.mark_dirty;
          probe_d  = 1'b0;
          status_d = 1'b0;
        end
      end
      dtm_pkg::StCheck: begin
        unique case (cmd_q)
          dtm_pkg::CmdMark: begin
            x_d = xs_w;  xs_d = xs_w;  xe_d = xe_w;
            y_d = ys_w;  ye_d = ye_w;
          end
          dtm_pkg::CmdResize: begin
            nh_d = CW'(nh_w);  nv_d = CW'(nv_w);
            x_d = rect_q.lo_x;  xs_d = rect_q.lo_x;  xe_d = rect_q.hi_x;
            y_d = rect_q.lo_y;  ye_d = rect_q.hi_y;
            dst_d = '0;
            cnt_d = '0;
            if (rect_q.empty || nh_w > dtm_pkg::tc_t'(dtm_pkg::MaxTiles) ||
                nv_w > dtm_pkg::tc_t'(dtm_pkg::MaxTiles)) begin
              gl_d = '0;  gt_d = '0;  cols_d = '0;  rows_d = '0;  count_d = '0;
              status_d = !rect_q.empty;
            end
          end
          dtm_pkg::CmdProbe: begin
            x_d = rect_q.lo_x;
            y_d = rect_q.lo_y;
          end
          default: ;
        endcase
      end
      dtm_pkg::StMult: begin
        if (prod > (2*CW)'(dtm_pkg::MaxTiles)) begin
          gl_d = '0;  gt_d = '0;  cols_d = '0;  rows_d = '0;  count_d = '0;
          status_d = 1'b1;
        end
      end
      dtm_pkg::StRow: begin
        // Row base of the live bank; only meaningful while the row is in the grid.
        row_d = CW'(CW'(y_q - gt_x) * cols_q);
      end
      dtm_pkg::StRd: begin
        addr_d   = raddr;
        inside_d = (x_q >= gl_x) && (x_q < gr_x) && (y_q >= gt_x) && (y_q < gb_x);
      end
      dtm_pkg::StWr: begin
        unique case (cmd_q)
          dtm_pkg::CmdMark: begin
            count_d = count_q + CW'(dv_q) - CW'(rd_live);
          end
          dtm_pkg::CmdResize: begin
            cnt_d = cnt_q + CW'(inside_q & rd_live);
            dst_d = dst_q + AW'(1);
            if (last_x && last_y) begin
              bank_d  = !bank_q;
              gl_d    = GW'(rect_q.lo_x);
              gt_d    = GW'(rect_q.lo_y);
              cols_d  = nh_q;
              rows_d  = nv_q;
              count_d = cnt_q + CW'(inside_q & rd_live);
            end
          end
          dtm_pkg::CmdProbe: probe_d = rd_live;
          default: ;
        endcase
        if (last_x) begin
          x_d = xs_q;
          y_d = y_q + dtm_pkg::tc_t'(1);
        end else begin
          x_d = x_q + dtm_pkg::tc_t'(1);
        end
      end
      dtm_pkg::StFin: begin
        if (fin_go) begin
          ovalid_d = 1'b1;
          otot_d   = count_q;
          oprobe_d = probe_q;
          ostat_d  = status_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dtm_pkg::StIdle;
      gl_q     <= '0;
      gt_q     <= '0;
      cols_q   <= '0;
      rows_q   <= '0;
      count_q  <= '0;
      bank_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      gl_q     <= gl_d;
      gt_q     <= gt_d;
      cols_q   <= cols_d;
      rows_q   <= rows_d;
      count_q  <= count_d;
      bank_q   <= bank_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    rect_q   <= rect_d;
    dv_q     <= dv_d;
    nh_q     <= nh_d;
    nv_q     <= nv_d;
    row_q    <= row_d;
    cnt_q    <= cnt_d;
    x_q      <= x_d;
    y_q      <= y_d;
    xs_q     <= xs_d;
    xe_q     <= xe_d;
    ye_q     <= ye_d;
    addr_q   <= addr_d;
    dst_q    <= dst_d;
    inside_q <= inside_d;
    probe_q  <= probe_d;
    status_q <= status_d;
    otot_q   <= otot_d;
    oprobe_q <= oprobe_d;
    ostat_q  <= ostat_d;
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.dirty_total = otot_q;
  assign out_o.probe_dirty = oprobe_q;
  assign out_o.status      = ostat_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(dtm_pkg::MaxTiles))
    else $error("dirty count exceeds capacity");

  a_grid_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cols_q * rows_q) <= (2*CW)'(dtm_pkg::MaxTiles))
    else $error("grid exceeds capacity");

  a_one_bank_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we_a && we_b))
    else $error("both flag banks written in one cycle");

  a_bank_flip_resize: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bank_q != $past(bank_q)) |-> ($past(cmd_q) == dtm_pkg::CmdResize))
    else $error("bank flipped outside a resize");

endmodule

[tb/sv/dirty_tile_map_tb.sv]
// Self-checking testbench for the dirty tile map: directed and random commands.
module dirty_tile_map_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dtm_pkg::*;

  localparam int NumRandom  = 680;
  localparam int CycleLimit = 3000000;

  typedef struct {
    cmd_e   op;
    coord_t l;
    coord_t t;
    coord_t r;
    coord_t b;
    logic   mark_dirty;
  } tile_cmd_t;

  typedef struct {
    logic [CntW-1:0] dirty_total;
    logic            probe_dirty;
    logic            status;
  } tile_res_t;

  // Holds a copy of the grid and the queue of results still to come.
  class tile_map_checker;
    bit        flags[MaxTiles];
    longint    org_x, org_y, cols, rows, count;
    tile_res_t pending_results[$];
    int        mismatches;

    function new();
      foreach (flags[k]) flags[k] = 0;
      org_x = 0; org_y = 0; cols = 0; rows = 0; count = 0;
      mismatches = 0;
    endfunction

    function longint floor_tile(longint x);
      return x >>> TileShift;
    endfunction

    function longint ceil_tile(longint x);
      return (x + TilePixels - 1) >>> TileShift;
    endfunction

    function void clear_grid();
      org_x = 0; org_y = 0; cols = 0; rows = 0; count = 0;
    endfunction

    function void apply_mark(longint l, longint t, longint r, longint b, bit v);
      longint tl, tt, tr, tb, gr, gb, idx;
      tl = floor_tile(l); tt = floor_tile(t);
      tr = ceil_tile(r);  tb = ceil_tile(b);
      gr = org_x + cols;  gb = org_y + rows;
      if (tl >= gr || tr <= org_x || tt >= gb || tb <= org_y) return;
      if (tl < org_x) tl = org_x;
      if (tr > gr) tr = gr;
      if (tt < org_y) tt = org_y;
      if (tb > gb) tb = gb;
      for (longint j = tt; j < tb; j++) begin
        for (longint i = tl; i < tr; i++) begin
          idx = (i - org_x) + (j - org_y) * cols;
          if (idx < 0 || idx >= MaxTiles) continue;
          count += longint'(v) - longint'(flags[idx]);
          flags[idx] = v;
        end
      end
    endfunction

    function bit apply_resize(longint l, longint t, longint r, longint b);
      bit     fresh[MaxTiles];
      longint tl, tt, nh, nv, gi, gj, oi, total;
      if (l >= r || t >= b) begin
        clear_grid();
        return 0;
      end
      tl = floor_tile(l); tt = floor_tile(t);
      nh = ceil_tile(r) - tl;
      nv = ceil_tile(b) - tt;
      if (nh * nv > MaxTiles) begin
        clear_grid();
        return 1;
      end
      foreach (fresh[k]) fresh[k] = 0;
      total = 0;
      for (longint j = 0; j < nv; j++) begin
        for (longint i = 0; i < nh; i++) begin
          gi = tl + i; gj = tt + j;
          if (gi >= org_x && gi < org_x + cols && gj >= org_y && gj < org_y + rows) begin
            oi = (gi - org_x) + (gj - org_y) * cols;
            if (oi >= 0 && oi < MaxTiles && flags[oi]) begin
              fresh[i + j * nh] = 1;
              total++;
            end
          end
        end
      end
      flags = fresh;
      org_x = tl; org_y = tt; cols = nh; rows = nv; count = total;
      return 0;
    endfunction

    function bit read_tile(longint x, longint y);
      longint tx, ty, idx;
      tx = floor_tile(x); ty = floor_tile(y);
      if (tx < org_x || tx >= org_x + cols || ty < org_y || ty >= org_y + rows) return 0;
      idx = (tx - org_x) + (ty - org_y) * cols;
      if (idx < 0 || idx >= MaxTiles) return 0;
      return flags[idx];
    endfunction

    function void note_command(tile_cmd_t c);
      tile_res_t res;
      res.probe_dirty = 0;
      res.status = 0;
      case (c.op)
        CmdMark:   apply_mark(c.l, c.t, c.r, c.b, c.mark_dirty);
        CmdResize: res.status = apply_resize(c.l, c.t, c.r, c.b);
        CmdProbe:  res.probe_dirty = read_tile(c.l, c.t);
        default: ;
      endcase
      res.dirty_total = CntW'(count);
      pending_results.push_back(res);
    endfunction

    function void check_result(tile_res_t got);
      tile_res_t exp_res;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: total %0d probe %0b status %0b",
                   got.dirty_total, got.probe_dirty, got.status);
        return;
      end
      exp_res = pending_results.pop_front();
      if (got.dirty_total !== exp_res.dirty_total || got.probe_dirty !== exp_res.probe_dirty ||
          got.status !== exp_res.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected total %0d probe %0b status %0b, got %0d %0b %0b",
                   exp_res.dirty_total, exp_res.probe_dirty, exp_res.status,
                   got.dirty_total, got.probe_dirty, got.status);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  dtm_cmd_if cmd_bus ();
  dtm_res_if res_bus ();

  dirty_tile_map uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_bus.sink),
    .out_o  (res_bus.source)
  );

  tile_map_checker checker_h = new();

  int  cycles;
  int  hold_left;
  int  burst_left;
  int  grid_px_x, grid_px_y, grid_w_px, grid_h_px;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("dirty_tile_map regression: fail");
      $finish;
    end
  end

  // The receiver switches among stall patterns; a long hold-off overrides them.
  initial begin
    int stall_mode;
    int phase;
    stall_mode = 0;
    phase = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      phase++;
      if (phase % 300 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: res_bus.ready <= 1'b1;
          1: res_bus.ready <= ($urandom_range(0, 3) != 0);
          2: res_bus.ready <= ((phase % 7) < 4);
          default: res_bus.ready <= ($urandom_range(0, 1) != 0);
        endcase
      end
    end
  end

  // Results are sampled mid-cycle; valid and ready then hold until the next edge.
  initial begin
    tile_res_t got;
    forever begin
      @(negedge clk_i);
      if (rst_ni && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
        got.dirty_total = res_bus.dirty_total;
        got.probe_dirty = res_bus.probe_dirty;
        got.status      = res_bus.status;
        checker_h.check_result(got);
      end
    end
  end

  task automatic send_cmd(input tile_cmd_t c);
    bit taken;
    cmd_bus.valid      <= 1'b1;
    cmd_bus.cmd        <= c.op;
    cmd_bus.left       <= c.l;
    cmd_bus.top        <= c.t;
    cmd_bus.right      <= c.r;
    cmd_bus.bottom     <= c.b;
    cmd_bus.mark_dirty <= c.mark_dirty;
    do begin
      @(negedge clk_i);
      taken = (cmd_bus.ready === 1'b1);
      @(posedge clk_i);
    end while (!taken);
    checker_h.note_command(c);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic send_fields(input cmd_e op, input int l, input int t, input int r,
                             input int b, input bit v);
    tile_cmd_t c;
    c.op = op;
    c.l = coord_t'(l); c.t = coord_t'(t); c.r = coord_t'(r); c.b = coord_t'(b);
    c.mark_dirty = v;
    send_cmd(c);
  endtask

  // The sender goes quiet while it waits, so the last beat is not offered again.
  task automatic wait_drained();
    cmd_bus.valid <= 1'b0;
    while (checker_h.pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic int clamp_coord(longint x);
    if (x > 8388607) return 8388607;
    if (x < -8388608) return -8388608;
    return int'(x);
  endfunction

  function automatic int near_px(int base, int span);
    return clamp_coord(longint'(base) + $urandom_range(0, span + 64) - 32);
  endfunction

  // Random commands stay mostly around the current grid; some are pure noise.
  task automatic send_random();
    tile_cmd_t c;
    int        pick;
    int        cols, rows, org;
    pick = $urandom_range(0, 99);
    c.mark_dirty = $urandom_range(0, 1);
    if (pick < 15) begin
      cols = ($urandom_range(0, 150) == 0) ? 64 : $urandom_range(1, 16);
      rows = (cols == 64) ? 64 : $urandom_range(1, 16);
      if ($urandom_range(0, 2) == 0) begin
        grid_px_x = near_px(grid_px_x, grid_w_px);
        grid_px_y = near_px(grid_px_y, grid_h_px);
      end else begin
        org = ($urandom_range(0, 5) == 0) ? 524288 - 20 : $urandom_range(0, 6000);
        grid_px_x = clamp_coord(longint'(($urandom_range(0, 1) ? org : -org - 20)) * 16
                                + $urandom_range(0, 15));
        org = ($urandom_range(0, 5) == 0) ? 524288 - 20 : $urandom_range(0, 6000);
        grid_px_y = clamp_coord(longint'(($urandom_range(0, 1) ? org : -org - 20)) * 16
                                + $urandom_range(0, 15));
      end
      grid_w_px = cols * 16 - $urandom_range(0, 15);
      grid_h_px = rows * 16 - $urandom_range(0, 15);
      c.op = CmdResize;
      c.l = coord_t'(grid_px_x);
      c.t = coord_t'(grid_px_y);
      c.r = coord_t'(clamp_coord(longint'(grid_px_x) + grid_w_px));
      c.b = coord_t'(clamp_coord(longint'(grid_px_y) + grid_h_px));
    end else if (pick < 60) begin
      c.op = CmdMark;
      c.l = coord_t'(near_px(grid_px_x, grid_w_px));
      c.t = coord_t'(near_px(grid_px_y, grid_h_px));
      c.r = coord_t'(clamp_coord(longint'(c.l) + $urandom_range(0, 80) - 8));
      c.b = coord_t'(clamp_coord(longint'(c.t) + $urandom_range(0, 80) - 8));
    end else if (pick < 88) begin
      c.op = CmdProbe;
      c.l = coord_t'(near_px(grid_px_x, grid_w_px));
      c.t = coord_t'(near_px(grid_px_y, grid_h_px));
      c.r = coord_t'($urandom);
      c.b = coord_t'($urandom);
    end else begin
      c.op = cmd_e'($urandom_range(0, 3));
      c.l = coord_t'($urandom);
      c.t = coord_t'($urandom);
      c.r = coord_t'($urandom);
      c.b = coord_t'($urandom);
    end
    send_cmd(c);
  endtask

  initial begin
    int idle_cycles;
    cycles = 0;
    hold_left = 0;
    burst_left = 0;
    grid_px_x = 0; grid_px_y = 0; grid_w_px = 64; grid_h_px = 64;
    rst_ni = 1'b0;
    cmd_bus.valid = 1'b0;
    cmd_bus.cmd = CmdNone;
    cmd_bus.left = '0;
    cmd_bus.top = '0;
    cmd_bus.right = '0;
    cmd_bus.bottom = '0;
    cmd_bus.mark_dirty = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    send_fields(CmdProbe, 0, 0, 0, 0, 0);
    send_fields(CmdMark, -100, -100, 100, 100, 1);
    send_fields(CmdResize, 50, 10, 50, 90, 0);
    send_fields(CmdResize, -40, -33, 20, 5, 0);
    send_fields(CmdMark, -8388608, -8388608, 8388607, 8388607, 1);
    send_fields(CmdProbe, -40, -33, 0, 0, 0);
    send_fields(CmdProbe, 20, 5, 0, 0, 0);
    send_fields(CmdMark, -17, -17, -17, -17, 0);
    send_fields(CmdMark, 15, 0, 3, -20, 0);
    send_fields(CmdMark, 500, 500, 600, 600, 0);
    send_fields(CmdProbe, -17, -17, 0, 0, 0);
    send_fields(CmdResize, -20, -40, 60, 30, 0);
    send_fields(CmdNone, 1, 2, 3, 4, 1);
    send_fields(CmdResize, 0, 0, 1024, 1024, 0);
    send_fields(CmdMark, 0, 0, 1024, 1024, 1);
    send_fields(CmdProbe, 1023, 1023, 0, 0, 0);
    send_fields(CmdResize, 0, 0, 1025, 1024, 0);
    send_fields(CmdResize, -8388608, -8388608, 8388607, 8388607, 0);
    send_fields(CmdResize, 8388600, 8388600, 8388607, 8388607, 0);
    send_fields(CmdMark, 8388607, 8388607, 8388607, 8388607, 1);
    send_fields(CmdProbe, 8388607, 8388607, -1, -1, 0);
    send_fields(CmdProbe, -8388608, -8388608, 0, 0, 0);
    send_fields(CmdResize, 8388607, 0, -8388608, 16, 0);

    for (int n = 0; n < NumRandom; n++) begin
      if (n == 250) hold_left = 600;
      if (n == 450) wait_drained();
      send_random();
    end
    cmd_bus.valid <= 1'b0;

    idle_cycles = 0;
    while (checker_h.pending_results.size() != 0 && idle_cycles < 100000) begin
      @(posedge clk_i);
      idle_cycles++;
    end
    repeat (50) @(posedge clk_i);
    if (checker_h.mismatches == 0 && checker_h.pending_results.size() == 0) begin
      $display("dirty_tile_map regression: pass");
    end else begin
      $display("dirty_tile_map regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
src/dtm_pkg.sv
src/dtm_if.sv
src/dtm_ram.sv
src/dtm_bounds.sv
src/dirty_tile_map.sv
tb/sv/dirty_tile_map_tb.sv
